// ===== src/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants of the spring force accumulator
// Field widths, lane command codes, the lane control struct and the
// saturating accumulator update.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int FORCE_W          = 48;
  localparam int STIFF_W          = 32;
  localparam int REST_W           = 31;
  localparam int VID_W            = 10;
  localparam int POS_W            = 32;
  localparam int FRAC_BITS        = 16;
  localparam int DEF_NUM_VERTICES = 1024;
  localparam int DEF_COORD_WIDTH  = 32;

  localparam logic [STIFF_W-1:0] STIFF_RESET = 32'h0001_0000;
  localparam logic               OP_APPLY     = 1'b0;
  localparam logic               OP_READ      = 1'b1;
  localparam logic               REG_STIFFNESS = 1'b0;

  localparam logic signed [FORCE_W-1:0] F48_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] F48_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  // Commands from the sequencer to one axis lane.
  typedef enum logic [2:0] {
    LN_HOLD    = 3'd0,
    LN_LOAD_SQ = 3'd1,
    LN_MUL     = 3'd2,
    LN_LOAD_P  = 3'd3,
    LN_DIV     = 3'd4,
    LN_LOAD_KT = 3'd5,
    LN_CLAMP   = 3'd6
  } lane_cmd_t;

  typedef struct packed {
    lane_cmd_t cmd;
    logic      delneg;
    logic      zero;
  } lane_ctrl_t;

  // Saturating add or subtract; the top bit of the result flags a clamp.
  function automatic logic [FORCE_W:0] sat_acc(input logic [FORCE_W-1:0] acc,
                                               input logic [FORCE_W-1:0] f,
                                               input logic sub);
    logic [FORCE_W:0] s;
    logic [FORCE_W:0] r;
    if (sub) begin
      s = {acc[FORCE_W-1], acc} - {f[FORCE_W-1], f};
    end else begin
      s = {acc[FORCE_W-1], acc} + {f[FORCE_W-1], f};
    end
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      r = {1'b1, (s[FORCE_W] ? F48_MIN : F48_MAX)};
    end else begin
      r = {1'b0, s[FORCE_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/sfa_ram.sv =====
// ----------------------------------------------------------------------------
// sfa_ram: generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sfa_lane.sv =====
// ----------------------------------------------------------------------------
// sfa_lane: one axis of the spring force datapath
// Radix-2 shift-add multiplier and restoring divider sharing one product
// register, followed by the force clamp.
// ----------------------------------------------------------------------------
module sfa_lane import sfa_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int DW = COORD_WIDTH + 1,
  localparam int MW = (REST_W > DW) ? REST_W : DW,
  localparam int QW = (MW > STIFF_W) ? MW : STIFF_W,
  localparam int PW = MW + ((DW > STIFF_W) ? DW : STIFF_W)
) (
  input  logic                   clk,
  input  lane_ctrl_t             ctrl,
  input  logic [COORD_WIDTH-1:0] pos_a,
  input  logic [COORD_WIDTH-1:0] pos_b,
  input  logic [MW-1:0]          delmag,
  input  logic [DW-1:0]          span,
  input  logic [STIFF_W-1:0]     stiffness,
  output logic [PW-1:0]          prod,
  output logic [FORCE_W-1:0]     force_val
);

  logic [DW-1:0]         d_now;
  logic [DW-1:0]         dm_now;
  logic [DW-1:0]         dm;
  logic                  dneg;
  logic [PW-1:0]         mcand;
  logic [QW-1:0]         mplier;
  logic [DW-1:0]         rem;
  logic [DW:0]           rsh;
  logic [DW:0]           rdiff;
  logic                  ge;
  logic [PW+FORCE_W-1:0] mx;
  logic                  big;
  logic [FORCE_W-1:0]    low;
  logic [FORCE_W-1:0]    force_next;

  assign d_now  = {pos_a[COORD_WIDTH-1], pos_a} - {pos_b[COORD_WIDTH-1], pos_b};
  assign dm_now = d_now[DW-1] ? (~d_now + DW'(1)) : d_now;

  assign rsh   = {rem, prod[PW-1]};
  assign rdiff = rsh - {1'b0, span};
  assign ge    = (rsh >= {1'b0, span});

  // Magnitude is floor(k*t / 2^16); anything at or above 2^47 clamps.
  assign mx  = {{FORCE_W{1'b0}}, prod} >> FRAC_BITS;
  assign big = |mx[PW+FORCE_W-1:FORCE_W-1];
  assign low = {1'b0, mx[FORCE_W-2:0]};

  always_comb begin
    if (ctrl.zero) begin
      force_next = '0;
    end else if (dneg ^ ctrl.delneg) begin
      force_next = big ? F48_MIN : (~low + FORCE_W'(1));
    end else begin
      force_next = big ? F48_MAX : low;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      LN_HOLD: begin
      end
      LN_LOAD_SQ: begin
        dneg   <= d_now[DW-1];
        dm     <= dm_now;
        mcand  <= PW'(dm_now);
        mplier <= QW'(dm_now);
        prod   <= '0;
      end
      LN_MUL: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= {mcand[PW-2:0], 1'b0};
        mplier <= {1'b0, mplier[QW-1:1]};
      end
      LN_LOAD_P: begin
        mcand  <= PW'(dm);
        mplier <= QW'(delmag);
        prod   <= '0;
        rem    <= '0;
      end
      LN_DIV: begin
        rem  <= ge ? rdiff[DW-1:0] : rsh[DW-1:0];
        prod <= {prod[PW-2:0], ge};
      end
      LN_LOAD_KT: begin
        mcand  <= prod;
        mplier <= QW'(stiffness);
        prod   <= '0;
      end
      LN_CLAMP: begin
        force_val <= force_next;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/spring_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// spring_force_accumulator: Hooke force per spring with per-vertex sums
// Bit-serial square, square root, multiply and divide, with saturating
// accumulators held in one RAM.
// ----------------------------------------------------------------------------
// An apply transfer carries one spring; the block returns the force on the
// first vertex, adds it to that vertex's sum and subtracts it from the
// second's. A read transfer returns one vertex's sum and clears it. One item
// is worked at a time. With DW = COORD_WIDTH+1, MW = max(31, DW),
// QW = max(MW, 32) and PW = MW + max(DW, 32), an apply item is worked by
// radix-2 iterations over these widths: the square and the square root
// step one bit per cycle, the three axis lanes then step a shift-add
// multiply, a restoring divide and the stiffness multiply, and the
// accumulator RAM takes a read and a write for each vertex. After reset a
// clearing pass writes zero to every RAM entry, one per cycle; input is
// stalled meanwhile, while register writes are taken as ever. The next item
// is taken once the previous result has moved into the output register,
// even while that result still waits for its output transfer.
// ----------------------------------------------------------------------------
module spring_force_accumulator import sfa_pkg::*; #(
  parameter int NUM_VERTICES = DEF_NUM_VERTICES,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [VID_W-1:0]          vertex_a,
  input  logic [VID_W-1:0]          vertex_b,
  input  logic signed [POS_W-1:0]   pos_a_x,
  input  logic signed [POS_W-1:0]   pos_a_y,
  input  logic signed [POS_W-1:0]   pos_a_z,
  input  logic signed [POS_W-1:0]   pos_b_x,
  input  logic signed [POS_W-1:0]   pos_b_y,
  input  logic signed [POS_W-1:0]   pos_b_z,
  input  logic [REST_W-1:0]         rest_length,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FORCE_W-1:0] force_x,
  output logic signed [FORCE_W-1:0] force_y,
  output logic signed [FORCE_W-1:0] force_z,
  output logic                      saturated
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = (REST_W > DW) ? REST_W : DW;
  localparam int QW   = (MW > STIFF_W) ? MW : STIFF_W;
  localparam int PW   = MW + ((DW > STIFF_W) ? DW : STIFF_W);
  localparam int SW   = 2 * DW;
  localparam int AW   = $clog2(NUM_VERTICES);
  localparam int SCW  = $clog2(PW);
  localparam int CNTW = (AW > SCW) ? AW : SCW;
  localparam int XW   = 17;
  localparam int EW   = POS_W + 16;

  typedef enum logic [16:0] {
    S_CLEAR = 17'b00000000000000001,
    S_IDLE  = 17'b00000000000000010,
    S_SQ    = 17'b00000000000000100,
    S_SUM   = 17'b00000000000001000,
    S_SQRT  = 17'b00000000000010000,
    S_DELTA = 17'b00000000000100000,
    S_PMUL  = 17'b00000000001000000,
    S_DIV   = 17'b00000000010000000,
    S_KLOAD = 17'b00000000100000000,
    S_KMUL  = 17'b00000001000000000,
    S_CLAMP = 17'b00000010000000000,
    S_RDA   = 17'b00000100000000000,
    S_WRA   = 17'b00001000000000000,
    S_RDB   = 17'b00010000000000000,
    S_WRB   = 17'b00100000000000000,
    S_RRD   = 17'b01000000000000000,
    S_RWR   = 17'b10000000000000000
  } state_t;

  state_t state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;

  logic [STIFF_W-1:0] stiffness;
  logic [VID_W-1:0]   va, vb;
  logic [REST_W-1:0]  rest;
  logic               sat;
  logic               pending;

  // Configuration: one register, the shared spring constant.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STIFFNESS) ? stiffness : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFF_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STIFFNESS)) begin
      stiffness <= pwdata;
    end
  end

  // Coordinates are taken as their low COORD_WIDTH bits, sign extended.
  logic [EW-1:0]          ext_a [3];
  logic [EW-1:0]          ext_b [3];
  logic [COORD_WIDTH-1:0] lpos_a [3];
  logic [COORD_WIDTH-1:0] lpos_b [3];
  logic [PW-1:0]          prod [3];
  logic [FORCE_W-1:0]     lforce [3];
  lane_ctrl_t             lctrl;

  assign ext_a[0] = EW'(pos_a_x);
  assign ext_a[1] = EW'(pos_a_y);
  assign ext_a[2] = EW'(pos_a_z);
  assign ext_b[0] = EW'(pos_b_x);
  assign ext_b[1] = EW'(pos_b_y);
  assign ext_b[2] = EW'(pos_b_z);

  // Square root state: the sum of squares shifts out two bits per step.
  logic [SW-1:0]   s_sh;
  logic [DW-1:0]   rt;
  logic [DW+1:0]   rm;
  logic [DW+3:0]   rsh;
  logic [DW+3:0]   trial;
  logic [DW+3:0]   rdiff;
  logic [SW-1:0]   ssum;
  logic [REST_W:0] rest_ext;
  logic [MW:0]     delta;
  logic [MW-1:0]   delmag;
  logic            delneg;

  assign rsh   = {rm, s_sh[SW-1:SW-2]};
  assign trial = {2'b00, rt, 2'b01};
  assign rdiff = rsh - trial;
  assign ssum  = prod[0][SW-1:0] + prod[1][SW-1:0] + prod[2][SW-1:0];

  // delta = rest - dist, signed; only its magnitude and sign go on.
  assign rest_ext = {1'b0, rest};
  assign delta    = (MW+1)'(rest_ext) - (MW+1)'(rt);
  assign delneg   = delta[MW];
  assign delmag   = delneg ? ((~delta[MW-1:0]) + MW'(1)) : delta[MW-1:0];

  assign lctrl.delneg = delneg;
  assign lctrl.zero   = (rt == '0);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign lpos_a[i] = ext_a[i][COORD_WIDTH-1:0];
    assign lpos_b[i] = ext_b[i][COORD_WIDTH-1:0];
    sfa_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
      .clk       (clk),
      .ctrl      (lctrl),
      .pos_a     (lpos_a[i]),
      .pos_b     (lpos_b[i]),
      .delmag    (delmag),
      .span      (rt),
      .stiffness (stiffness),
      .prod      (prod[i]),
      .force_val (lforce[i])
    );
  end

  // Accumulator RAM, one entry {z, y, x} per vertex.
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [3*FORCE_W-1:0]   wdata, rdata;
  logic [XW-1:0]          va_ext, vb_ext;
  logic                   va_ok, vb_ok;
  logic [FORCE_W:0]       upd [3];
  logic                   upd_sub;
  logic [FORCE_W-1:0]     res [3];
  logic                   res_sat;

  assign va_ext = XW'(va);
  assign vb_ext = XW'(vb);
  assign va_ok  = (va_ext < XW'(NUM_VERTICES));
  assign vb_ok  = (vb_ext < XW'(NUM_VERTICES));

  sfa_ram #(.WIDTH(3*FORCE_W), .DEPTH(NUM_VERTICES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign upd_sub = (state == S_WRB);
  for (genvar i = 0; i < 3; i++) begin : g_upd
    assign upd[i] = sat_acc(rdata[i*FORCE_W +: FORCE_W], lforce[i], upd_sub);
  end

  // Input is taken only when idle and the staging register is empty.
  assign in_stall = (state != S_IDLE) || pending;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CNTW'(1);
    lctrl.cmd  = LN_HOLD;
    we         = 1'b0;
    waddr      = va_ext[AW-1:0];
    raddr      = va_ext[AW-1:0];
    wdata      = {upd[2][FORCE_W-1:0], upd[1][FORCE_W-1:0], upd[0][FORCE_W-1:0]};
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[AW-1:0];
        wdata = '0;
        if (cnt == CNTW'(NUM_VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid && !pending) begin
          if (op == OP_APPLY) begin
            lctrl.cmd  = LN_LOAD_SQ;
            state_next = S_SQ;
          end else begin
            state_next = S_RRD;
          end
        end
      end
      S_SQ: begin
        lctrl.cmd = LN_MUL;
        if (cnt == CNTW'(QW - 1)) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (cnt == CNTW'(DW - 1)) begin
          state_next = S_DELTA;
        end
      end
      S_DELTA: begin
        lctrl.cmd  = LN_LOAD_P;
        cnt_next   = '0;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        lctrl.cmd = LN_MUL;
        if (cnt == CNTW'(QW - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        lctrl.cmd = LN_DIV;
        if (cnt == CNTW'(PW - 1)) begin
          state_next = S_KLOAD;
        end
      end
      S_KLOAD: begin
        lctrl.cmd  = LN_LOAD_KT;
        cnt_next   = '0;
        state_next = S_KMUL;
      end
      S_KMUL: begin
        lctrl.cmd = LN_MUL;
        if (cnt == CNTW'(QW - 1)) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        lctrl.cmd  = LN_CLAMP;
        state_next = S_RDA;
      end
      S_RDA: begin
        state_next = S_WRA;
      end
      S_WRA: begin
        we         = va_ok;
        raddr      = vb_ext[AW-1:0];
        state_next = S_RDB;
      end
      S_RDB: begin
        raddr      = vb_ext[AW-1:0];
        state_next = S_WRB;
      end
      S_WRB: begin
        we         = vb_ok;
        waddr      = vb_ext[AW-1:0];
        state_next = S_IDLE;
      end
      S_RRD: begin
        state_next = S_RWR;
      end
      S_RWR: begin
        we         = va_ok;
        wdata      = '0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Item capture and square root iteration.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !pending) begin
      va   <= vertex_a;
      vb   <= vertex_b;
      rest <= rest_length;
    end
    if (state == S_SUM) begin
      s_sh <= ssum;
      rt   <= '0;
      rm   <= '0;
    end else if (state == S_SQRT) begin
      s_sh <= {s_sh[SW-3:0], 2'b00};
      if (rsh >= trial) begin
        rm <= rdiff[DW+1:0];
        rt <= {rt[DW-2:0], 1'b1};
      end else begin
        rm <= rsh[DW+1:0];
        rt <= {rt[DW-2:0], 1'b0};
      end
    end
    if (state == S_CLAMP) begin
      sat <= 1'b0;
    end else if (state == S_WRA) begin
      sat <= va_ok && (upd[0][FORCE_W] || upd[1][FORCE_W] || upd[2][FORCE_W]);
    end
  end

  // Result staging: a finished result waits here until the output register
  // is free; new input stalls until it has moved on.
  always_ff @(posedge clk) begin
    if (state == S_WRB) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= lforce[i];
      end
      res_sat <= sat || (vb_ok && (upd[0][FORCE_W] || upd[1][FORCE_W] || upd[2][FORCE_W]));
    end else if (state == S_RWR) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= va_ok ? rdata[i*FORCE_W +: FORCE_W] : '0;
      end
      res_sat <= 1'b0;
    end
    if (pending && (!out_valid || !out_stall)) begin
      force_x   <= res[0];
      force_y   <= res[1];
      force_z   <= res[2];
      saturated <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pending && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else begin
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        if (state == S_WRB || state == S_RWR) begin
          pending <= 1'b1;
        end
      end
    end
  end

endmodule
